// ----- rtl/core/dirac_kinetic_spinor_rotation_macros.svh -----
// assertion macros used by the checker file of the spinor rotation block
// no dependencies; include guard keeps it single
`ifndef DIRAC_KINETIC_SPINOR_ROTATION_MACROS_SVH
`define DIRAC_KINETIC_SPINOR_ROTATION_MACROS_SVH

// same-cycle implication
`define DKSR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DKSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/dksr_pkg.sv -----
// types, constants and the arctangent table of the spinor rotation block
// no dependencies
package dksr_pkg;

   localparam int WAVE_W     = 16;
   localparam int MAG_W      = 16;
   localparam int DT_W       = 16;
   localparam int PROD_P_W   = MAG_W + DT_W;
   localparam int TURN_W     = 29;
   localparam int TURN_PROD_W = PROD_P_W + TURN_W;
   localparam int PHASE_W    = 32;
   localparam int PHASE_LSB  = 24;
   localparam int CORDIC_W   = 34;
   localparam int SC_W       = 18;
   localparam int NUM_W      = SC_W + WAVE_W;
   localparam int ABS_W      = NUM_W - 1;
   localparam int QUO_W      = 17;
   localparam int DIV_LAT    = QUO_W + 2;
   localparam int FRAC_SHIFT = 15;
   localparam int ATAN_ENTRIES = 24;

   localparam logic [TURN_W-1:0]     TURN_SCALE   = 29'd341782638;
   localparam logic [CORDIC_W-1:0]   CORDIC_START = 34'd652032874;
   localparam logic [QUO_W-1:0]      UNIT_QUO     = 17'd32768;
   localparam logic [DT_W-1:0]       HALF_TIME_STEP_RESET = 16'd41;
   localparam logic [PHASE_W-1:0]    EIGHTH_TURN  = 32'h2000_0000;

   // register indexes
   localparam logic REG_HALF_TIME_STEP = 1'b0;

   // quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic                       valid;
      logic [1:0]                 quad;
      logic signed [CORDIC_W-1:0] angle;
   } rot_in_type;

   typedef struct packed {
      logic                       valid;
      logic [1:0]                 quad;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
   } rot_out_type;

   typedef struct packed {
      logic                    valid;
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic [MAG_W-1:0]        mag;
   } div_in_type;

   typedef struct packed {
      logic                    valid;
      logic signed [QUO_W-1:0] bx;
      logic signed [QUO_W-1:0] by;
   } div_out_type;

   // arctangent of 2^-i in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/dksr_cordic.sv -----
// pipelined rotation-mode cordic, one iteration per register stage
// depends on dksr_pkg
module dksr_cordic #(
   parameter int ITERATIONS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dksr_pkg::rot_in_type  rot_in,
   output dksr_pkg::rot_out_type rot_out
);
   import dksr_pkg::*;

   logic [ITERATIONS-1:0]      valid_ff, valid_in;
   logic [1:0]                 quad_ff [ITERATIONS];
   logic [1:0]                 quad_in [ITERATIONS];
   logic signed [CORDIC_W-1:0] x_ff [ITERATIONS];
   logic signed [CORDIC_W-1:0] y_ff [ITERATIONS];
   logic signed [CORDIC_W-1:0] z_ff [ITERATIONS];
   logic signed [CORDIC_W-1:0] x_in [ITERATIONS];
   logic signed [CORDIC_W-1:0] y_in [ITERATIONS];
   logic signed [CORDIC_W-1:0] z_in [ITERATIONS];

   // one micro-rotation per stage
   always_comb begin
      logic signed [CORDIC_W-1:0] xp, yp, zp, at;
      for (int i = 0; i < ITERATIONS; i++) begin
         if (i == 0) begin
            xp = signed'(CORDIC_START);
            yp = '0;
            zp = rot_in.angle;
            valid_in[i] = rot_in.valid;
            quad_in[i]  = rot_in.quad;
         end else begin
            xp = x_ff[i-1];
            yp = y_ff[i-1];
            zp = z_ff[i-1];
            valid_in[i] = valid_ff[i-1];
            quad_in[i]  = quad_ff[i-1];
         end
         at = signed'({2'b00, atan_turn(5'(i))});
         if (zp[CORDIC_W-1]) begin
            x_in[i] = xp + (yp >>> i);
            y_in[i] = yp - (xp >>> i);
            z_in[i] = zp + at;
         end else begin
            x_in[i] = xp - (yp >>> i);
            y_in[i] = yp + (xp >>> i);
            z_in[i] = zp - at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int i = 0; i < ITERATIONS; i++) begin
         quad_ff[i] <= quad_in[i];
         x_ff[i]    <= x_in[i];
         y_ff[i]    <= y_in[i];
         z_ff[i]    <= z_in[i];
      end
   end

   assign rot_out.valid = valid_ff[ITERATIONS-1];
   assign rot_out.quad  = quad_ff[ITERATIONS-1];
   assign rot_out.x     = x_ff[ITERATIONS-1];
   assign rot_out.y     = y_ff[ITERATIONS-1];

endmodule

// ----- rtl/core/dksr_div.sv -----
// two-lane pipelined restoring divider, one quotient bit per stage,
// truncating toward zero and clamped to plus or minus one; depends on dksr_pkg
module dksr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dksr_pkg::div_in_type  div_in,
   output dksr_pkg::div_out_type div_out
);
   import dksr_pkg::*;

   // front stage: magnitudes, signs and overflow
   logic             pre_valid_ff;
   logic [MAG_W-1:0] pre_mag_ff;
   logic [1:0]       pre_neg_ff, pre_ovf_ff;
   logic [ABS_W-1:0] pre_abs_ff [2];
   logic [1:0]       pre_neg_in, pre_ovf_in;
   logic [ABS_W-1:0] pre_abs_in [2];

   // bit stages
   logic [QUO_W-1:0] st_valid_ff, st_valid_in;
   logic [MAG_W-1:0] st_mag_ff [QUO_W];
   logic [1:0]       st_neg_ff [QUO_W];
   logic [1:0]       st_ovf_ff [QUO_W];
   logic [ABS_W-1:0] st_rem_ff [QUO_W][2];
   logic [QUO_W-1:0] st_quo_ff [QUO_W][2];
   logic [ABS_W-1:0] st_rem_in [QUO_W][2];
   logic [QUO_W-1:0] st_quo_in [QUO_W][2];

   // output stage
   logic                    out_valid_ff;
   logic signed [QUO_W-1:0] out_q_ff [2];
   logic signed [QUO_W-1:0] out_q_in [2];

   always_comb begin
      logic signed [NUM_W-1:0] n;
      logic        [NUM_W-1:0] a;
      for (int l = 0; l < 2; l++) begin
         n = (l == 0) ? div_in.num_x : div_in.num_y;
         a = n[NUM_W-1] ? unsigned'(-n) : unsigned'(n);
         pre_neg_in[l] = n[NUM_W-1];
         pre_abs_in[l] = a[ABS_W-1:0];
         pre_ovf_in[l] = (a[ABS_W-1:0] >= {div_in.mag, {QUO_W{1'b0}}});
      end
   end

   // restoring steps, most significant quotient bit first
   always_comb begin
      logic [ABS_W-1:0] rp, trial;
      logic [QUO_W-1:0] qp;
      logic [MAG_W-1:0] mp;
      for (int k = 0; k < QUO_W; k++) begin
         st_valid_in[k] = (k == 0) ? pre_valid_ff : st_valid_ff[k-1];
         mp = (k == 0) ? pre_mag_ff : st_mag_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            rp = (k == 0) ? pre_abs_ff[l] : st_rem_ff[k-1][l];
            qp = (k == 0) ? '0 : st_quo_ff[k-1][l];
            trial = ABS_W'(mp) << (QUO_W - 1 - k);
            if (rp >= trial) begin
               st_rem_in[k][l] = rp - trial;
               st_quo_in[k][l] = qp | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
               st_rem_in[k][l] = rp;
               st_quo_in[k][l] = qp;
            end
         end
      end
   end

   // clamp and restore sign
   always_comb begin
      logic [QUO_W-1:0] q;
      for (int l = 0; l < 2; l++) begin
         q = st_quo_ff[QUO_W-1][l];
         if (st_ovf_ff[QUO_W-1][l] || q > UNIT_QUO) begin
            q = UNIT_QUO;
         end
         out_q_in[l] = st_neg_ff[QUO_W-1][l] ? -signed'(q) : signed'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
         st_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= div_in.valid;
         st_valid_ff  <= st_valid_in;
         out_valid_ff <= st_valid_ff[QUO_W-1];
      end
      pre_mag_ff <= div_in.mag;
      pre_neg_ff <= pre_neg_in;
      pre_ovf_ff <= pre_ovf_in;
      pre_abs_ff <= pre_abs_in;
      for (int k = 0; k < QUO_W; k++) begin
         st_mag_ff[k] <= (k == 0) ? pre_mag_ff : st_mag_ff[k-1];
         st_neg_ff[k] <= (k == 0) ? pre_neg_ff : st_neg_ff[k-1];
         st_ovf_ff[k] <= (k == 0) ? pre_ovf_ff : st_ovf_ff[k-1];
         st_rem_ff[k] <= st_rem_in[k];
         st_quo_ff[k] <= st_quo_in[k];
      end
      out_q_ff <= out_q_in;
   end

   assign div_out.valid = out_valid_ff;
   assign div_out.bx    = out_q_ff[0];
   assign div_out.by    = out_q_ff[1];

endmodule

// ----- rtl/core/dirac_kinetic_spinor_rotation.sv -----
// top level of the free dirac kinetic spinor rotation block
// depends on dksr_pkg, dksr_cordic and dksr_div
//
// One momentum point enters per transfer: start high with busy low accepts
// wave_x, wave_y, wave_magnitude and the four complex spinor components.
// busy is always low, so a point may be given in every clock cycle.
// The rotated spinor comes out through the register stages listed below, marked
// by rsp_valid for exactly one cycle; the receiver cannot hold it off and the
// pipeline never stalls.
// Throughput is one point per cycle: every step (phase multiply, each cordic
// iteration, each quotient bit of the two-lane divider, products, sums and
// saturation) is a register stage of its own.
// A zero magnitude returns the spinor unchanged through the same stages.
// half_time_step is written over the csr port at byte address 0 and should
// only change while no point is in flight.
// Synchronous reset empties the pipeline and sets half_time_step to 41.
module dirac_kinetic_spinor_rotation #(
   parameter int AMPLITUDE_WIDTH     = 16,
   parameter int ROTATION_ITERATIONS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // item channel
   input  logic                              start,
   output logic                              busy,
   input  logic signed [dksr_pkg::WAVE_W-1:0] req_wave_x,
   input  logic signed [dksr_pkg::WAVE_W-1:0] req_wave_y,
   input  logic [dksr_pkg::MAG_W-1:0]        req_wave_magnitude,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in0_re,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in0_im,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in1_re,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in1_im,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in2_re,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in2_im,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in3_re,
   input  logic signed [AMPLITUDE_WIDTH-1:0] req_in3_im,
   // result channel
   output logic                              rsp_valid,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out0_re,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out0_im,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out1_re,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out1_im,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out2_re,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out2_im,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out3_re,
   output logic signed [AMPLITUDE_WIDTH-1:0] rsp_out3_im,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import dksr_pkg::*;

   localparam int AW         = AMPLITUDE_WIDTH;
   localparam int ITER       = ROTATION_ITERATIONS;
   localparam int CS_TAP     = 4 + ITER;
   localparam int PROD_TAP   = CS_TAP + 1 + DIV_LAT;
   localparam int OUT_TAP    = PROD_TAP + 2;
   localparam int SIDE_DEPTH = OUT_TAP + 1;
   localparam int PW         = SC_W + AW;
   localparam int ACC_W      = PW + 2;
   localparam int RND_W      = ACC_W - FRAC_SHIFT;

   typedef struct packed {
      logic signed [WAVE_W-1:0] wave_x;
      logic signed [WAVE_W-1:0] wave_y;
      logic [MAG_W-1:0]         mag;
      logic [7:0][AW-1:0]       amp;
   } side_type;

   // configuration register
   logic [DT_W-1:0] dt_ff;
   logic            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_HALF_TIME_STEP);
   assign csr_prdata = (csr_paddr[2] == REG_HALF_TIME_STEP)
                       ? {{(32 - DT_W){1'b0}}, dt_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= HALF_TIME_STEP_RESET;
      end else if (csr_wr) begin
         dt_ff <= csr_pwdata[DT_W-1:0];
      end
   end

   // never stalls
   assign busy = 1'b0;

   // side line carries the point alongside the arithmetic
   side_type side_ff [SIDE_DEPTH];
   side_type side_in;

   assign side_in.wave_x = req_wave_x;
   assign side_in.wave_y = req_wave_y;
   assign side_in.mag    = req_wave_magnitude;
   assign side_in.amp    = {req_in3_im, req_in3_re, req_in2_im, req_in2_re,
                            req_in1_im, req_in1_re, req_in0_im, req_in0_re};

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // angle: magnitude times time step, then scaled to turns
   logic                     in_valid_ff, p_valid_ff, ph_valid_ff;
   logic [PROD_P_W-1:0]      p_ff;
   logic [PHASE_W-1:0]       phase_ff;
   logic [TURN_PROD_W-1:0]   turn_prod;
   logic [PHASE_W-1:0]       phase_bias;
   logic [PHASE_W-1:0]       resid;
   rot_in_type               rot_in_ff, rot_in_in;
   rot_out_type              rot_out;

   assign turn_prod  = TURN_PROD_W'(p_ff) * TURN_PROD_W'(TURN_SCALE);
   assign phase_bias = phase_ff + EIGHTH_TURN;
   assign resid      = phase_ff - {phase_bias[PHASE_W-1 -: 2], {(PHASE_W - 2){1'b0}}};

   always_comb begin
      rot_in_in.valid = ph_valid_ff;
      rot_in_in.quad  = phase_bias[PHASE_W-1 -: 2];
      rot_in_in.angle = signed'({{(CORDIC_W - PHASE_W){resid[PHASE_W-1]}}, resid});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         p_valid_ff      <= 1'b0;
         ph_valid_ff     <= 1'b0;
         rot_in_ff.valid <= 1'b0;
      end else begin
         in_valid_ff     <= start && !busy;
         p_valid_ff      <= in_valid_ff;
         ph_valid_ff     <= p_valid_ff;
         rot_in_ff.valid <= rot_in_in.valid;
      end
      p_ff            <= PROD_P_W'(side_ff[0].mag) * PROD_P_W'(dt_ff);
      phase_ff        <= turn_prod[PHASE_LSB +: PHASE_W];
      rot_in_ff.quad  <= rot_in_in.quad;
      rot_in_ff.angle <= rot_in_in.angle;
   end

   dksr_cordic #(
      .ITERATIONS(ITER)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .rot_in (rot_in_ff),
      .rot_out(rot_out)
   );

   // quadrant fix-up and rounding of cosine and sine
   logic                       cs_valid_ff;
   logic signed [SC_W-1:0]     cos_ff, sin_ff;
   logic signed [CORDIC_W-1:0] cx, sy, cx_r, sy_r;

   always_comb begin
      unique case (rot_out.quad)
         QUAD_0: begin cx = rot_out.x;  sy = rot_out.y;  end
         QUAD_1: begin cx = -rot_out.y; sy = rot_out.x;  end
         QUAD_2: begin cx = -rot_out.x; sy = -rot_out.y; end
         QUAD_3: begin cx = rot_out.y;  sy = -rot_out.x; end
         default: begin cx = rot_out.x; sy = rot_out.y; end
      endcase
      cx_r = (cx + signed'(CORDIC_W'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      sy_r = (sy + signed'(CORDIC_W'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_valid_ff <= 1'b0;
      end else begin
         cs_valid_ff <= rot_out.valid;
      end
      cos_ff <= cx_r[SC_W-1:0];
      sin_ff <= sy_r[SC_W-1:0];
   end

   // numerators for the two coefficient divisions
   div_in_type              div_in_ff;
   div_out_type             div_out;
   logic signed [SC_W-1:0]  cos_dl_ff [DIV_LAT + 1];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_in_ff.valid <= 1'b0;
      end else begin
         div_in_ff.valid <= cs_valid_ff;
      end
      div_in_ff.num_x <= NUM_W'(sin_ff) * NUM_W'(side_ff[CS_TAP].wave_x);
      div_in_ff.num_y <= NUM_W'(sin_ff) * NUM_W'(side_ff[CS_TAP].wave_y);
      div_in_ff.mag   <= side_ff[CS_TAP].mag;
      cos_dl_ff[0]    <= cos_ff;
      for (int i = 1; i <= DIV_LAT; i++) begin
         cos_dl_ff[i] <= cos_dl_ff[i-1];
      end
   end

   dksr_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_in (div_in_ff),
      .div_out(div_out)
   );

   // products of the matrix entries with the amplitudes
   logic                 prod_valid_ff, sum_valid_ff, rsp_valid_ff;
   logic signed [PW-1:0] pc_ff [8];
   logic signed [PW-1:0] px_ff [8];
   logic signed [PW-1:0] py_ff [8];
   logic signed [PW-1:0] pc_in [8];
   logic signed [PW-1:0] px_in [8];
   logic signed [PW-1:0] py_in [8];

   always_comb begin
      logic signed [AW-1:0] a;
      for (int j = 0; j < 8; j++) begin
         a = signed'(side_ff[PROD_TAP].amp[j]);
         pc_in[j] = PW'(cos_dl_ff[DIV_LAT]) * PW'(a);
         px_in[j] = PW'(div_out.bx) * PW'(a);
         py_in[j] = PW'(div_out.by) * PW'(a);
      end
   end

   // sums for both component pairs
   logic signed [ACC_W-1:0] acc_ff [8];
   logic signed [ACC_W-1:0] acc_in [8];

   always_comb begin
      int b;
      for (int p = 0; p < 2; p++) begin
         b = 4 * p;
         acc_in[b]   = ACC_W'(pc_ff[b])   - ACC_W'(py_ff[b+2]) + ACC_W'(px_ff[b+3]);
         acc_in[b+1] = ACC_W'(pc_ff[b+1]) - ACC_W'(py_ff[b+3]) - ACC_W'(px_ff[b+2]);
         acc_in[b+2] = ACC_W'(py_ff[b])   + ACC_W'(px_ff[b+1]) + ACC_W'(pc_ff[b+2]);
         acc_in[b+3] = ACC_W'(py_ff[b+1]) - ACC_W'(px_ff[b])   + ACC_W'(pc_ff[b+3]);
      end
   end

   // rounding, saturation and the zero-magnitude bypass
   logic signed [AW-1:0] out_ff [8];
   logic signed [AW-1:0] out_in [8];

   always_comb begin
      logic signed [ACC_W-1:0] r;
      logic signed [RND_W-1:0] hi, lo, rs;
      hi = signed'(RND_W'((1 << (AW - 1)) - 1));
      lo = -hi - signed'(RND_W'(1));
      for (int j = 0; j < 8; j++) begin
         r  = (acc_ff[j] + signed'(ACC_W'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
         rs = signed'(r[RND_W-1:0]);
         if (side_ff[OUT_TAP].mag == '0) begin
            out_in[j] = signed'(side_ff[OUT_TAP].amp[j]);
         end else if (rs > hi) begin
            out_in[j] = hi[AW-1:0];
         end else if (rs < lo) begin
            out_in[j] = lo[AW-1:0];
         end else begin
            out_in[j] = rs[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= div_out.valid;
         sum_valid_ff  <= prod_valid_ff;
         rsp_valid_ff  <= sum_valid_ff;
      end
      pc_ff  <= pc_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out0_re = out_ff[0];
   assign rsp_out0_im = out_ff[1];
   assign rsp_out1_re = out_ff[2];
   assign rsp_out1_im = out_ff[3];
   assign rsp_out2_re = out_ff[4];
   assign rsp_out2_im = out_ff[5];
   assign rsp_out3_re = out_ff[6];
   assign rsp_out3_im = out_ff[7];

endmodule

// ----- rtl/core/dksr_checker.sv -----
// port-level checker of the spinor rotation block and its bind
// depends on dirac_kinetic_spinor_rotation_macros.svh and the top level
`include "dirac_kinetic_spinor_rotation_macros.svh"

module dksr_checker #(
   parameter int AMPLITUDE_WIDTH     = 16,
   parameter int ROTATION_ITERATIONS = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [15:0]                       req_wave_magnitude,
   input logic signed [AMPLITUDE_WIDTH-1:0] req_in0_re,
   input logic signed [AMPLITUDE_WIDTH-1:0] req_in3_im,
   input logic                              rsp_valid,
   input logic signed [AMPLITUDE_WIDTH-1:0] rsp_out0_re,
   input logic signed [AMPLITUDE_WIDTH-1:0] rsp_out3_im
);
   localparam int LATENCY = ROTATION_ITERATIONS + 28;

   // pipeline is empty right after reset
   `DKSR_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "result after reset")

   // every accepted point comes out later, marked by rsp_valid
   `DKSR_ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##LATENCY rsp_valid, "result lost")

   // no result without a point accepted at the matching cycle
   `DKSR_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "result invented")

   // zero magnitude passes the spinor through, checked on out0_re and out3_im
   `DKSR_ASSERT_IMPLY(a_zero_pass, clock, reset, start && !busy && req_wave_magnitude == 16'd0, ##LATENCY (rsp_out0_re == $past(req_in0_re, LATENCY) && rsp_out3_im == $past(req_in3_im, LATENCY)), "bypass mismatch")

endmodule

bind dirac_kinetic_spinor_rotation dksr_checker #(
   .AMPLITUDE_WIDTH    (AMPLITUDE_WIDTH),
   .ROTATION_ITERATIONS(ROTATION_ITERATIONS)
) u_dksr_checker (.*);

// ----- tb/tb_top.sv -----
// testbench for the dirac kinetic spinor rotation block
// depends on dksr_pkg and dirac_kinetic_spinor_rotation; self-checking with a fixed-point predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dksr_pkg::*;

   localparam int AW = 16;
   localparam int ITER = 16;
   localparam int LATENCY = ITER + 28;

   typedef struct {
      logic signed [AW-1:0] v [8];
   } spinor_type;

   // expected rotated spinors and field comparison
   class spinor_scoreboard;
      spinor_type pending [$];
      int errors = 0;

      function void note_point(spinor_type e);
         pending.push_back(e);
      endfunction

      function void check_spinor(spinor_type got);
         string names [8] = '{"out0_re", "out0_im", "out1_re", "out1_im",
                              "out2_re", "out2_im", "out3_re", "out3_im"};
         spinor_type e;
         if (pending.size() == 0) begin
            $error("result with no point pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int j = 0; j < 8; j++)
            if (e.v[j] !== got.v[j]) begin
               $error("%s expected %0d actual %0d", names[j], e.v[j], got.v[j]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_wave_x = 0, req_wave_y = 0;
   logic [15:0] req_wave_magnitude = 0;
   logic signed [AW-1:0] req_amp [8];
   logic rsp_valid;
   logic signed [AW-1:0] rsp_amp [8];
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic [15:0] time_step = HALF_TIME_STEP_RESET;
   spinor_scoreboard board;
   int idle_pct = 36;

   initial for (int j = 0; j < 8; j++) req_amp[j] = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   dirac_kinetic_spinor_rotation #(.AMPLITUDE_WIDTH(AW), .ROTATION_ITERATIONS(ITER)) u_dut (
      .clock, .reset, .start, .busy,
      .req_wave_x, .req_wave_y, .req_wave_magnitude,
      .req_in0_re(req_amp[0]), .req_in0_im(req_amp[1]),
      .req_in1_re(req_amp[2]), .req_in1_im(req_amp[3]),
      .req_in2_re(req_amp[4]), .req_in2_im(req_amp[5]),
      .req_in3_re(req_amp[6]), .req_in3_im(req_amp[7]),
      .rsp_valid,
      .rsp_out0_re(rsp_amp[0]), .rsp_out0_im(rsp_amp[1]),
      .rsp_out1_re(rsp_amp[2]), .rsp_out1_im(rsp_amp[3]),
      .rsp_out2_re(rsp_amp[4]), .rsp_out2_im(rsp_amp[5]),
      .rsp_out3_re(rsp_amp[6]), .rsp_out3_im(rsp_amp[7]),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [AW-1:0] round_sat(longint acc);
      longint r = floor_sh(acc + 16384, 15);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[AW-1:0];
   endfunction

   // cosine and sine of |k|*dt in q1.15 through a turn-phase cordic
   function automatic void rotation_angle(logic [15:0] mag, logic [15:0] dt,
                                          output longint c15, output longint s15);
      logic [63:0] p;
      logic [31:0] phase, d;
      logic [1:0] q;
      longint z, x, y, xs, ys, cx, sy;
      p = 64'(mag) * 64'(dt);
      p = p * 64'd341782638;
      phase = p[55:24];
      q = 2'((phase + EIGHTH_TURN) >> 30);
      d = phase - {q, 30'd0};
      z = longint'(signed'(d));
      x = 652032874;
      y = 0;
      for (int i = 0; i < ITER; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atan_turn(5'(i)));
         end else begin
            x += ys; y -= xs; z += longint'(atan_turn(5'(i)));
         end
      end
      case (q)
         QUAD_0:  begin cx = x;  sy = y;  end
         QUAD_1:  begin cx = -y; sy = x;  end
         QUAD_2:  begin cx = -x; sy = -y; end
         default: begin cx = y;  sy = -x; end
      endcase
      c15 = floor_sh(cx + 16384, 15);
      s15 = floor_sh(sy + 16384, 15);
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > 32768) return 32768;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // predicted output spinor for one momentum point
   function automatic spinor_type rotate_spinor(logic signed [15:0] kx, logic signed [15:0] ky,
                                               logic [15:0] mag, spinor_type a);
      spinor_type o;
      longint c, s, bx, by, ur, ui, lr, li, p0r, p0i, p1r, p1i;
      if (mag == 0) return a;
      rotation_angle(mag, time_step, c, s);
      bx = clamp_unit((s * kx) / longint'(mag));
      by = clamp_unit((s * ky) / longint'(mag));
      ur = -by; ui = -bx; lr = by; li = -bx;
      for (int pr = 0; pr < 2; pr++) begin
         p0r = a.v[pr*4]; p0i = a.v[pr*4+1]; p1r = a.v[pr*4+2]; p1i = a.v[pr*4+3];
         o.v[pr*4]   = round_sat(c * p0r + ur * p1r - ui * p1i);
         o.v[pr*4+1] = round_sat(c * p0i + ur * p1i + ui * p1r);
         o.v[pr*4+2] = round_sat(lr * p0r - li * p0i + c * p1r);
         o.v[pr*4+3] = round_sat(lr * p0i + li * p0r + c * p1i);
      end
      return o;
   endfunction

   // time-step register write over the csr port
   task automatic write_time_step(logic [15:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 3'(REG_HALF_TIME_STEP) * 3'd4; csr_pwdata <= {16'd0, val};
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      time_step = val;
   endtask

   // one point transfer, with random idle cycles before it
   task automatic send_point(logic signed [15:0] kx, logic signed [15:0] ky,
                             logic [15:0] mag, spinor_type a);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_wave_x <= kx; req_wave_y <= ky; req_wave_magnitude <= mag;
      for (int j = 0; j < 8; j++) req_amp[j] <= a.v[j];
      do @(posedge clock); while (busy);
      board.note_point(rotate_spinor(kx, ky, mag, a));
   endtask

   task automatic finish_phase();
      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic spinor_type random_spinor();
      spinor_type a;
      for (int j = 0; j < 8; j++) a.v[j] = AW'($urandom);
      return a;
   endfunction

   // random point: mostly consistent magnitudes, some arbitrary
   task automatic random_point();
      logic signed [15:0] kx, ky;
      logic [15:0] mag;
      real r;
      kx = 16'($urandom); ky = 16'($urandom);
      if ($urandom_range(3) == 0) mag = 16'($urandom_range(36400));
      else begin
         r = $sqrt(real'(kx) * real'(kx) + real'(ky) * real'(ky));
         mag = (r > 36400.0) ? 16'd36400 : 16'($rtoi(r));
      end
      if ($urandom_range(19) == 0) mag = 0;
      send_point(kx, ky, mag, random_spinor());
   endtask

   // result monitor
   always @(posedge clock) begin
      spinor_type got;
      if (!reset && rsp_valid) begin
         for (int j = 0; j < 8; j++) got.v[j] = rsp_amp[j];
         board.check_spinor(got);
      end
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      spinor_type a;
      logic [15:0] steps [5] = '{16'd41, 16'd0, 16'd65535, 16'd4096, 16'd23456};
      board = new();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed points at the reset time step
      for (int j = 0; j < 8; j++) a.v[j] = 16'sh7fff;
      send_point(16'sh7fff, 16'sh7fff, 16'd36400, a);
      for (int j = 0; j < 8; j++) a.v[j] = 16'sh8000;
      send_point(16'sh8000, 16'sh8000, 16'd36400, a);
      send_point(16'sh8000, 16'sh7fff, 16'd0, a);
      send_point(16'sh7fff, 16'sh8000, 16'd1, a);
      send_point(16'sh7fff, 16'sh0000, 16'd65535, random_spinor());
      send_point(16'sh0000, 16'sh8000, 16'd8192, random_spinor());
      send_point(16'sh0000, 16'sh0000, 16'd100, random_spinor());
      finish_phase();

      // wide angles with clamped coefficients and wraps
      write_time_step(16'd65535);
      for (int j = 0; j < 8; j++) a.v[j] = (j % 2) ? 16'sh8000 : 16'sh7fff;
      send_point(16'sh8000, 16'sh8000, 16'd3, a);
      send_point(16'sh7fff, 16'sh7fff, 16'd65535, a);
      send_point(16'sh1234, 16'shedcb, 16'd12345, random_spinor());
      send_point(16'sh0000, 16'sh0000, 16'd0, random_spinor());
      finish_phase();

      // random phases over several time steps, one without idling
      for (int ph = 0; ph < 5; ph++) begin
         write_time_step(ph == 4 ? 16'($urandom) : steps[ph]);
         idle_pct = (ph == 2) ? 0 : 36;
         repeat (100) random_point();
         finish_phase();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
